// ===== hdl/rcpc_pkg.sv =====
// Shared types and constants for the ray versus convex polyhedron clipper.
// Used by the front, queue-side back end and the top level; depends on nothing.
package rcpc_pkg;

	localparam int unsigned COORD_W = 32;

	localparam logic signed [COORD_W-1:0] DIST_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [COORD_W-1:0] DIST_MIN = 32'sh8000_0000;

	typedef enum logic [1:0] {
		FE_IDLE,
		FE_MUL,
		FE_PUSH
	} fe_state_t;

	typedef enum logic [1:0] {
		BE_IDLE,
		BE_DIV,
		BE_UPD,
		BE_OUT
	} be_state_t;

endpackage

// ===== hdl/ray_convex_polyhedron_clip.sv =====
// Top level of the ray versus convex polyhedron clipper.
// Instantiates rcpc_front, rcpc_queue and rcpc_back; depends on rcpc_pkg.
//
// Each item is one face plane of a convex polyhedron together with the ray direction,
// in signed fixed point with FRAC_BITS fraction bits; the ray starts at the origin.
// After the item flagged last_face one result reports hit, and the interval resets.
// The front end takes one item at a time and accepts no other until it has queued it:
// it takes the item, forms the dot product over the four lanes on one shared 32x32
// multiplier, finishes the sum and queues it. The back end takes the item, runs a bit-serial
// divider per face (skipped for a parallel face or once the ray has missed) and updates
// the interval, so the sustained rate is set by the divider.
// A two-item queue between the two lets the front keep accepting while a result waits.
module ray_convex_polyhedron_clip
	import rcpc_pkg::*;
#(
	parameter int FRAC_BITS = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic signed [COORD_W-1:0] dir_x,
	input  logic signed [COORD_W-1:0] dir_y,
	input  logic signed [COORD_W-1:0] dir_z,
	input  logic signed [COORD_W-1:0] dir_w,
	input  logic signed [COORD_W-1:0] plane_a,
	input  logic signed [COORD_W-1:0] plane_b,
	input  logic signed [COORD_W-1:0] plane_c,
	input  logic signed [COORD_W-1:0] plane_d,
	input  logic                      last_face,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic                      hit
);

	localparam int VD_W = 66 - FRAC_BITS;
	localparam int QW   = VD_W + COORD_W + 1;

	logic          push, pop, q_full, q_empty;
	logic [QW-1:0] push_data, pop_data;

	rcpc_front #(.FRAC_BITS(FRAC_BITS), .VD_W(VD_W), .QW(QW)) u_front (
		.clk, .arst_n, .in_valid, .in_stall,
		.dir_x, .dir_y, .dir_z, .dir_w,
		.plane_a, .plane_b, .plane_c, .plane_d, .last_face,
		.push, .push_data, .q_full
	);

	rcpc_queue #(.W(QW)) u_queue (
		.clk, .arst_n, .push, .push_data, .full(q_full),
		.pop, .pop_data, .empty(q_empty)
	);

	rcpc_back #(.FRAC_BITS(FRAC_BITS), .VD_W(VD_W), .QW(QW)) u_back (
		.clk, .arst_n, .q_empty, .pop_data, .pop,
		.out_valid, .out_stall, .hit
	);

endmodule

// ===== hdl/rcpc_front.sv =====
// Front end: accepts one face item, forms the plane/direction dot product with one
// shared multiplier over the four lanes and pushes the floored dot product to the queue.
// Depends on rcpc_pkg.
module rcpc_front
	import rcpc_pkg::*;
#(
	parameter int FRAC_BITS = 16,
	parameter int VD_W      = 66 - FRAC_BITS,
	parameter int QW        = VD_W + 33
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic signed [COORD_W-1:0] dir_x,
	input  logic signed [COORD_W-1:0] dir_y,
	input  logic signed [COORD_W-1:0] dir_z,
	input  logic signed [COORD_W-1:0] dir_w,
	input  logic signed [COORD_W-1:0] plane_a,
	input  logic signed [COORD_W-1:0] plane_b,
	input  logic signed [COORD_W-1:0] plane_c,
	input  logic signed [COORD_W-1:0] plane_d,
	input  logic                      last_face,
	output logic                      push,
	output logic [QW-1:0]             push_data,
	input  logic                      q_full
);

	localparam int ACC_W = 66;

	fe_state_t state_q, state_nx;
	logic signed [COORD_W-1:0] dir_q [4];
	logic signed [COORD_W-1:0] pln_q [4];
	logic                      last_q;
	logic [2:0]                cnt_q;
	logic signed [63:0]        prod_q;
	logic signed [ACC_W-1:0]   acc_q;
	logic                      accept;

	assign accept = in_valid && !in_stall;

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			FE_IDLE: if (in_valid) state_nx = FE_MUL;
			FE_MUL:  if (cnt_q == 3'd4) state_nx = FE_PUSH;
			FE_PUSH: if (!q_full) state_nx = FE_IDLE;
			default: state_nx = FE_IDLE;
		endcase
	end

	always_comb begin
		in_stall = (state_q != FE_IDLE);
		push     = (state_q == FE_PUSH) && !q_full;
	end

	// Floor of the sum by 2^FRAC_BITS is an arithmetic shift, so only the upper bits go on.
	assign push_data = {last_q, pln_q[3], acc_q[ACC_W-1:FRAC_BITS]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FE_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_nx;
			if (accept) cnt_q <= '0;
			else if (state_q == FE_MUL) cnt_q <= cnt_q + 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			dir_q[0] <= dir_x;
			dir_q[1] <= dir_y;
			dir_q[2] <= dir_z;
			dir_q[3] <= dir_w;
			pln_q[0] <= plane_a;
			pln_q[1] <= plane_b;
			pln_q[2] <= plane_c;
			pln_q[3] <= plane_d;
			last_q   <= last_face;
			acc_q    <= '0;
		end else if (state_q == FE_MUL) begin
			// Lane cnt is multiplied while lane cnt-1 is summed.
			if (cnt_q != 3'd4) prod_q <= pln_q[cnt_q[1:0]] * dir_q[cnt_q[1:0]];
			if (cnt_q != 3'd0) acc_q <= acc_q + ACC_W'(prod_q);
		end
	end

endmodule

// ===== hdl/rcpc_queue.sv =====
// Two-entry queue that decouples the dot-product front end from the divide back end.
// Depends on nothing.
module rcpc_queue #(
	parameter int W = 83
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] push_data,
	output logic         full,
	input  logic         pop,
	output logic [W-1:0] pop_data,
	output logic         empty
);

	logic [W-1:0] mem_q [2];
	logic         wr_q, rd_q;
	logic [1:0]   cnt_q;

	assign full     = (cnt_q == 2'd2);
	assign empty    = (cnt_q == 2'd0);
	assign pop_data = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= !wr_q;
			if (pop) rd_q <= !rd_q;
			if (push && !pop) cnt_q <= cnt_q + 2'd1;
			else if (pop && !push) cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_data;
	end

endmodule

// ===== hdl/rcpc_back.sv =====
// Back end: divides -d by the dot product one quotient bit per cycle, saturates,
// updates the entry/exit interval and holds the hit result. Depends on rcpc_pkg.
module rcpc_back
	import rcpc_pkg::*;
#(
	parameter int FRAC_BITS = 16,
	parameter int VD_W      = 66 - FRAC_BITS,
	parameter int QW        = VD_W + 33
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          q_empty,
	input  logic [QW-1:0] pop_data,
	output logic          pop,
	output logic          out_valid,
	input  logic          out_stall,
	output logic          hit
);

	localparam int NUM_W = COORD_W + FRAC_BITS;
	localparam int CNT_W = $clog2(NUM_W + 1);
	localparam logic [NUM_W-1:0] POS_LIM = NUM_W'(33'h0_7FFF_FFFF);
	localparam logic [NUM_W-1:0] NEG_LIM = NUM_W'(33'h0_8000_0000);

	be_state_t state_q, state_nx;

	logic signed [VD_W-1:0]    in_vd;
	logic signed [COORD_W-1:0] in_d;
	logic                      in_last;
	logic signed [COORD_W:0]   neg_d;
	logic [COORD_W:0]          num_mag;

	logic signed [VD_W-1:0]    vd_q;
	logic signed [COORD_W-1:0] d_q;
	logic                      last_q;
	logic                      qneg_q;
	logic [VD_W-1:0]           den_q;
	logic [VD_W-1:0]           rem_q;
	logic [NUM_W-1:0]          nq_q;
	logic [CNT_W-1:0]          step_q;

	logic signed [COORD_W-1:0] entry_q, exit_q;
	logic                      missed_q;
	logic                      out_vld_q, hit_q;

	logic [VD_W:0]             trial;
	logic                      qbit;
	logic signed [COORD_W-1:0] t;
	logic signed [COORD_W-1:0] entry_nx, exit_nx;
	logic                      missed_nx;

	assign {in_last, in_d, in_vd} = pop_data;
	assign neg_d   = -{in_d[COORD_W-1], in_d};
	assign num_mag = neg_d[COORD_W] ? -neg_d : neg_d;

	assign trial = {rem_q, nq_q[NUM_W-1]};
	assign qbit  = (trial >= {1'b0, den_q});

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			BE_IDLE: if (!q_empty) state_nx = (missed_q || in_vd == '0) ? BE_UPD : BE_DIV;
			BE_DIV:  if (step_q == CNT_W'(NUM_W - 1)) state_nx = BE_UPD;
			BE_UPD:  state_nx = last_q ? BE_OUT : BE_IDLE;
			BE_OUT:  if (!out_stall) state_nx = BE_IDLE;
			default: state_nx = BE_IDLE;
		endcase
	end

	always_comb begin
		pop       = (state_q == BE_IDLE) && !q_empty;
		out_valid = out_vld_q;
		hit       = hit_q;
	end

	// Truncated quotient with sign restored, saturated to 32 bits.
	always_comb begin
		if (!qneg_q) t = (nq_q > POS_LIM) ? DIST_MAX : nq_q[COORD_W-1:0];
		else t = (nq_q > NEG_LIM) ? DIST_MIN : -nq_q[COORD_W-1:0];
	end

	always_comb begin
		entry_nx  = entry_q;
		exit_nx   = exit_q;
		missed_nx = missed_q;
		if (!missed_q) begin
			if (vd_q == '0) begin
				if (d_q > 0) missed_nx = 1'b1;
			end else if (!vd_q[VD_W-1]) begin
				if (t < 0) begin
					missed_nx = 1'b1;
				end else if (t < exit_q) begin
					exit_nx = t;
					if (entry_q > t) missed_nx = 1'b1;
				end
			end else if (t > entry_q) begin
				entry_nx = t;
				if (t > exit_q) missed_nx = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= BE_IDLE;
			entry_q   <= '0;
			exit_q    <= DIST_MAX;
			missed_q  <= 1'b0;
			out_vld_q <= 1'b0;
			step_q    <= '0;
		end else begin
			state_q <= state_nx;
			if (pop) step_q <= '0;
			else if (state_q == BE_DIV) step_q <= step_q + CNT_W'(1);
			if (state_q == BE_UPD) begin
				if (last_q) begin
					entry_q   <= '0;
					exit_q    <= DIST_MAX;
					missed_q  <= 1'b0;
					out_vld_q <= 1'b1;
				end else begin
					entry_q  <= entry_nx;
					exit_q   <= exit_nx;
					missed_q <= missed_nx;
				end
			end else if (state_q == BE_OUT && !out_stall) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			vd_q   <= in_vd;
			d_q    <= in_d;
			last_q <= in_last;
			qneg_q <= neg_d[COORD_W] ^ in_vd[VD_W-1];
			den_q  <= in_vd[VD_W-1] ? -in_vd : in_vd;
			rem_q  <= '0;
			nq_q   <= {num_mag[COORD_W-1:0], {FRAC_BITS{1'b0}}};
		end else if (state_q == BE_DIV) begin
			rem_q <= qbit ? VD_W'(trial - {1'b0, den_q}) : trial[VD_W-1:0];
			nq_q  <= {nq_q[NUM_W-2:0], qbit};
		end
		if (state_q == BE_UPD && last_q) hit_q <= !missed_nx;
	end

endmodule

// ===== hdl/rcpc_checker.sv =====
// Port-level checks for the clipper top level, bound to every instance of it.
// Depends on nothing but the top-level ports.
module rcpc_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_stall,
	input logic out_valid,
	input logic out_stall,
	input logic hit
);

	// A held result keeps its value until it is taken.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(hit))
		else $error("result changed while stalled");

	// The dot product keeps the front end busy after it takes an item.
	a_front_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall ##1 in_stall ##1 in_stall)
		else $error("front end took an item during its dot product");

	// A new result needs at least an interval update after the previous one leaves.
	a_out_gap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall |=> !out_valid)
		else $error("results delivered back to back");

endmodule

bind ray_convex_polyhedron_clip rcpc_checker u_rcpc_checker (
	.clk, .arst_n, .in_valid, .in_stall, .out_valid, .out_stall, .hit
);

// ===== verif/ray_convex_polyhedron_clip_checker.sv =====
// Checker for the ray versus convex polyhedron clipper: watches both channels,
// predicts hit/miss per polyhedron and compares. Depends on rcpc_pkg.
module ray_convex_polyhedron_clip_checker
	import rcpc_pkg::*;
#(
	parameter int FRAC_BITS = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	input  logic                      in_stall,
	input  logic signed [COORD_W-1:0] dir_x,
	input  logic signed [COORD_W-1:0] dir_y,
	input  logic signed [COORD_W-1:0] dir_z,
	input  logic signed [COORD_W-1:0] dir_w,
	input  logic signed [COORD_W-1:0] plane_a,
	input  logic signed [COORD_W-1:0] plane_b,
	input  logic signed [COORD_W-1:0] plane_c,
	input  logic signed [COORD_W-1:0] plane_d,
	input  logic                      last_face,
	input  logic                      out_valid,
	input  logic                      out_stall,
	input  logic                      hit,
	output int                        errors,
	output int                        pending,
	output int                        results_seen
);

	logic signed [COORD_W-1:0] entry_dist;
	logic signed [COORD_W-1:0] exit_dist;
	logic                      ray_missed;
	logic                      hit_queue[$];

	initial begin
		entry_dist = 0;
		exit_dist = DIST_MAX;
		ray_missed = 1'b0;
		errors = 0;
		results_seen = 0;
	end

	assign pending = hit_queue.size();

	task automatic report_mismatch(input string what);
		$display("MISMATCH at %0t: %s", $time, what);
		errors++;
	endtask

	// Clip the interval against one face; arithmetic is wide enough to stay exact.
	task automatic clip_face();
		logic signed [127:0] dot;
		logic signed [127:0] vd;
		logic signed [127:0] num;
		logic signed [127:0] quo;
		logic signed [COORD_W-1:0] t;
		dot = 128'(plane_a) * 128'(dir_x) + 128'(plane_b) * 128'(dir_y)
			+ 128'(plane_c) * 128'(dir_z) + 128'(plane_d) * 128'(dir_w);
		vd = dot >>> FRAC_BITS;
		if (!ray_missed) begin
			if (vd == 0) begin
				if (plane_d > 0)
					ray_missed = 1'b1;
			end else begin
				num = -(128'(plane_d) <<< FRAC_BITS);
				quo = num / vd;
				if (quo > 128'(DIST_MAX))
					t = DIST_MAX;
				else if (quo < 128'(DIST_MIN))
					t = DIST_MIN;
				else
					t = quo[COORD_W-1:0];
				if (vd > 0) begin
					if (t < 0)
						ray_missed = 1'b1;
					else if (t < exit_dist) begin
						exit_dist = t;
						if (entry_dist > exit_dist)
							ray_missed = 1'b1;
					end
				end else if (t > entry_dist) begin
					entry_dist = t;
					if (entry_dist > exit_dist)
						ray_missed = 1'b1;
				end
			end
		end
		if (last_face) begin
			hit_queue.insert(hit_queue.size(), !ray_missed);
			entry_dist = 0;
			exit_dist = DIST_MAX;
			ray_missed = 1'b0;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				clip_face();
			if (out_valid && !out_stall) begin
				results_seen++;
				if (hit_queue.size() == 0)
					report_mismatch("result with no polyhedron pending");
				else if (hit !== hit_queue.pop_front())
					report_mismatch($sformatf("hit=%b is wrong", hit));
			end
		end
	end

endmodule

// ===== verif/ray_convex_polyhedron_clip_tb.sv =====
// Testbench top for the ray versus convex polyhedron clipper: drives faces and
// stalls, gives the verdict. Depends on rcpc_pkg, the clipper top and the checker module.
module ray_convex_polyhedron_clip_tb;
	import rcpc_pkg::*;

	localparam int FRAC_BITS = 16;
	localparam int ONE = 1 << FRAC_BITS;
	localparam longint CYCLE_LIMIT = 64'd2_000_000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [COORD_W-1:0] dir_x = 0, dir_y = 0, dir_z = 0, dir_w = 0;
	logic signed [COORD_W-1:0] plane_a = 0, plane_b = 0, plane_c = 0, plane_d = 0;
	logic last_face = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic hit;
	int errors, pending, results_seen;
	int faces_sent = 0;
	int polyhedra = 0;
	longint cycles = 0;
	logic [COORD_W-1:0] ray[4];

	ray_convex_polyhedron_clip #(.FRAC_BITS(FRAC_BITS)) dut (.*);

	ray_convex_polyhedron_clip_checker #(.FRAC_BITS(FRAC_BITS)) checker_i (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles", cycles);
			$display("Test completed with failures");
			$finish;
		end
	end

	function automatic int gap_len();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 50)
			return 0;
		if (roll < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	// Receiver stalls at random, with calm stretches.
	always @(negedge clk) begin
		if (cycles % 4000 < 1000)
			out_stall <= 1'b0;
		else if ($urandom_range(0, 99) < 70)
			out_stall <= 1'b0;
		else
			out_stall <= ($urandom_range(0, 9) < 9) || ($urandom_range(0, 3) == 0);
	end

	// Valid stays high from one item to the next when there is no gap.
	task automatic send_face(input logic [COORD_W-1:0] a, b, c, d, input logic last);
		int gap;
		gap = (cycles % 5000 < 1500) ? 0 : gap_len();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		{dir_x, dir_y, dir_z, dir_w} = {ray[0], ray[1], ray[2], ray[3]};
		{plane_a, plane_b, plane_c, plane_d} = {a, b, c, d};
		last_face <= last;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
		faces_sent++;
		if (last)
			polyhedra++;
	endtask

	function automatic logic [COORD_W-1:0] rand_val();
		case ($urandom_range(0, 5))
			0: return $urandom;
			1: return DIST_MAX;
			2: return DIST_MIN;
			3: return $urandom_range(0, 2) - 1;
			default: return $signed($urandom_range(0, 8 * ONE)) - 4 * ONE;
		endcase
	endfunction

	// A box centered near the ray, axis-aligned faces n.x <= half + offset.
	task automatic send_box();
		int half;
		int off[3];
		int faces;
		int k;
		logic [COORD_W-1:0] p[4];
		half = $urandom_range(1, 4 * ONE);
		for (k = 0; k < 3; k++)
			off[k] = $signed($urandom_range(0, 8 * ONE)) - 4 * ONE;
		faces = $urandom_range(1, 6);
		for (k = 0; k < faces; k++) begin
			p = '{0, 0, 0, 0};
			p[k % 3] = (k < 3) ? ONE : -ONE;
			p[3] = (k < 3) ? -(half + off[k % 3]) : -(half - off[k % 3]);
			if ($urandom_range(0, 15) == 0)
				p[3] = rand_val();
			send_face(p[0], p[1], p[2], p[3], k == faces - 1);
		end
	endtask

	task automatic set_ray();
		int k;
		for (k = 0; k < 3; k++)
			ray[k] = ($urandom_range(0, 7) == 0) ? rand_val()
				: $signed($urandom_range(0, 4 * ONE)) - 2 * ONE;
		ray[3] = ($urandom_range(0, 9) == 0) ? rand_val() : 0;
	endtask

	initial begin
		ray = '{ONE, 0, 0, 0};
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: parallel faces, back/front faces, negative t, saturation.
		send_face(0, ONE, 0, ONE, 1'b1);
		send_face(0, ONE, 0, -ONE, 1'b1);
		send_face(ONE, 0, 0, ONE, 1'b1);
		send_face(-ONE, 0, 0, -ONE, 1'b1);
		send_face(ONE, 0, 0, -2 * ONE, 1'b0);
		send_face(-ONE, 0, 0, ONE, 1'b1);
		send_face(ONE, 0, 0, -ONE, 1'b0);
		send_face(-ONE, 0, 0, 3 * ONE, 1'b0);
		send_face(ONE, 0, 0, DIST_MAX, 1'b1);
		send_face(1, 0, 0, DIST_MIN, 1'b1);
		send_face(-1, 0, 0, DIST_MAX, 1'b1);
		send_face(DIST_MAX, 0, 0, DIST_MIN, 1'b1);
		ray = '{DIST_MIN, DIST_MAX, -1, 1};
		send_face(DIST_MIN, DIST_MAX, DIST_MIN, DIST_MAX, 1'b1);
		send_face(-1, 0, 0, 0, 1'b1);
		send_face(1, 0, 0, 0, 1'b1);
		ray = '{1, 0, 0, 0};
		send_face(-1, 0, 0, 5, 1'b1);
		ray = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF};
		send_face(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);

		while (faces_sent < 1950) begin
			set_ray();
			if ($urandom_range(0, 9) < 8)
				send_box();
			else
				send_face(rand_val(), rand_val(), rand_val(), rand_val(),
					$urandom_range(0, 1));
		end
		if (!last_face)
			send_face(0, 0, 0, 0, 1'b1);
		in_valid <= 1'b0;

		while (pending != 0)
			@(negedge clk);
		repeat (200) @(negedge clk);
		$display("Sent %0d faces in %0d polyhedra; %0d hit/miss results checked.",
			faces_sent, polyhedra, results_seen);
		if (errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
